// ===== sv/slsfp_pkg.sv =====
`default_nettype none

package slsfp_pkg;

    // Command codes of an input item.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Event codes of a result item.
    localparam logic [1:0] EV_BYTE    = 2'd0;
    localparam logic [1:0] EV_ACCEPT  = 2'd1;
    localparam logic [1:0] EV_DISCARD = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    localparam logic [7:0] SYNC_BYTE    = 8'hAA;
    localparam logic [7:0] CAPACITY_RST = 8'd255;

    // One input beat.
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  rx_byte;
        logic [15:0] timeout_ms;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] data;
        logic [7:0] position;
        logic [7:0] frame_length;
    } t_result;

    // Handshake between the input register and the parser stage.
    typedef struct packed {
        logic fire;
        logic free;
    } t_stage_ctl;

endpackage

`default_nettype wire

// ===== sv/slsfp_in_reg.sv =====
`default_nettype none

module slsfp_in_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  slsfp_pkg::t_item      i_item,
    input  wire                   i_free,
    output slsfp_pkg::t_stage_ctl o_ctl,
    output slsfp_pkg::t_item      o_item
);
    import slsfp_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;
    logic  fire;
    logic  accept;

    // The held beat moves on whenever the result register can take it.
    assign fire       = r_valid && i_free;
    assign o_in_stall = r_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_valid    = accept ? 1'b1 : (fire ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_ctl.fire = fire;
    assign o_ctl.free = i_free;
    assign o_item     = r_item;

endmodule

`default_nettype wire

// ===== sv/slsfp_core.sv =====
`default_nettype none

module slsfp_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  slsfp_pkg::t_stage_ctl i_ctl,
    input  slsfp_pkg::t_item      i_item,
    input  wire                   i_cfg_we,
    input  wire [7:0]             i_cfg_data,
    input  wire                   i_out_stall,
    output logic                  o_free,
    output logic                  o_out_valid,
    output slsfp_pkg::t_result    o_result
);
    import slsfp_pkg::*;

    // Parser phases.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SYNC = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;
    localparam logic [2:0] PH_CSUM = 3'd4;
    localparam logic [2:0] PH_RSSI = 3'd5;

    logic [7:0]  r_capacity;
    logic [2:0]  r_phase,   n_phase;
    logic [7:0]  r_sum,     n_sum;
    logic [7:0]  r_len,     n_len;
    logic [7:0]  r_index,   n_index;
    logic [15:0] r_elapsed, n_elapsed;
    logic [15:0] r_limit,   n_limit;
    logic        r_out_valid;
    t_result     r_result;
    logic        has_res;
    t_result     res;
    logic [7:0]  index_inc;
    logic [7:0]  b;

    assign b         = i_item.rx_byte;
    assign index_inc = r_index + 8'd1;

    // The result register is free when empty or being drained this cycle.
    assign o_free = !r_out_valid || !i_out_stall;

    // Next state and result for the beat at the parser stage.
    always_comb begin
        n_phase   = r_phase;
        n_sum     = r_sum;
        n_len     = r_len;
        n_index   = r_index;
        n_elapsed = r_elapsed;
        n_limit   = r_limit;
        has_res   = 1'b0;
        res.event_res = EV_BYTE;
        res.data      = 8'd0;
        res.position  = 8'd0;
        if (i_item.command == CMD_START) begin
            n_sum     = 8'd0;
            n_len     = 8'd0;
            n_index   = 8'd0;
            n_elapsed = 16'd0;
            n_limit   = i_item.timeout_ms;
            if (i_item.timeout_ms == 16'd0) begin
                n_phase       = PH_IDLE;
                has_res       = 1'b1;
                res.event_res = EV_TIMEOUT;
            end else begin
                n_phase = PH_SYNC;
            end
        end else if (r_phase != PH_IDLE && i_item.command == CMD_BYTE) begin
            case (r_phase)
                PH_SYNC: begin
                    if (b == SYNC_BYTE) begin
                        n_sum   = b;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len   = b;
                    n_sum   = r_sum + b;
                    n_index = 8'd0;
                    n_phase = (b != 8'd0 && b <= r_capacity) ? PH_BODY : PH_SYNC;
                end
                PH_BODY: begin
                    n_sum   = r_sum + b;
                    n_index = index_inc;
                    if (index_inc == r_len) begin
                        n_phase = PH_CSUM;
                    end
                    has_res       = 1'b1;
                    res.event_res = EV_BYTE;
                    res.data      = b;
                    res.position  = r_index;
                end
                PH_CSUM: begin
                    if (b == r_sum) begin
                        n_phase = PH_RSSI;
                    end else begin
                        n_phase       = PH_SYNC;
                        has_res       = 1'b1;
                        res.event_res = EV_DISCARD;
                    end
                end
                PH_RSSI: begin
                    n_phase       = PH_IDLE;
                    has_res       = 1'b1;
                    res.event_res = EV_ACCEPT;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end else if (r_phase != PH_IDLE && i_item.command == CMD_TICK) begin
            if (r_elapsed < r_limit) begin
                n_elapsed = r_elapsed + 16'd1;
            end
            if (n_elapsed >= r_limit) begin
                n_phase       = PH_IDLE;
                has_res       = 1'b1;
                res.event_res = EV_TIMEOUT;
            end
        end
        res.frame_length = n_len;
    end

    // Parser state and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAPACITY_RST;
            r_phase     <= PH_IDLE;
            r_sum       <= 8'd0;
            r_len       <= 8'd0;
            r_index     <= 8'd0;
            r_elapsed   <= 16'd0;
            r_limit     <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_ctl.fire) begin
                r_phase     <= n_phase;
                r_sum       <= n_sum;
                r_len       <= n_len;
                r_index     <= n_index;
                r_elapsed   <= n_elapsed;
                r_limit     <= n_limit;
                r_out_valid <= has_res;
            end else if (i_ctl.free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.fire && has_res) begin
            r_result <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

// ===== sv/sync_length_sum_frame_parser_unit.sv =====
// Each input beat is held in the input register, then moves to the result register when that is free.
// Throughput: one input beat per cycle while the output is not stalled, set by the single parser stage
// between the input register and the result register.
// Reset (synchronous, active low) returns the parser to idle, clears its
// counters and sets the payload capacity to 255.
`default_nettype none

module sync_length_sum_frame_parser_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [1:0]  i_command,
    input  wire [7:0]  i_rx_byte,
    input  wire [15:0] i_timeout_ms,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [1:0] o_event_res,
    output logic [7:0] o_data,
    output logic [7:0] o_position,
    output logic [7:0] o_frame_length,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [7:0]  i_cfg_data
);
    import slsfp_pkg::*;

    t_item      in_item;
    t_item      stage_item;
    t_stage_ctl ctl;
    t_result    result;
    logic       free;

    assign in_item.command    = i_command;
    assign in_item.rx_byte    = i_rx_byte;
    assign in_item.timeout_ms = i_timeout_ms;

    // The capacity register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    slsfp_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (in_item),
        .i_free     (free),
        .o_ctl      (ctl),
        .o_item     (stage_item)
    );

    slsfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_item      (stage_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_event_res    = result.event_res;
    assign o_data         = result.data;
    assign o_position     = result.position;
    assign o_frame_length = result.frame_length;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
    import slsfp_pkg::*;

    // Command code the block leaves unused; it must be ignored.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int DRAIN_CYCLES = 6;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 80;

    typedef enum logic [2:0] {
        ST_IDLE, ST_HUNT, ST_LEN, ST_BODY, ST_SUM, ST_RSSI
    } t_rx_state;

    typedef enum logic [1:0] {FR_GOOD, FR_BAD_SUM, FR_CUT} t_frame_kind;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [1:0]  i_command    = CMD_START;
    logic [7:0]  i_rx_byte    = 8'h00;
    logic [15:0] i_timeout_ms = 16'h0000;
    logic        i_out_stall  = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic [7:0]  i_cfg_data   = 8'h00;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_event_res;
    logic [7:0]  o_data;
    logic [7:0]  o_position;
    logic [7:0]  o_frame_length;
    logic        o_cfg_ready;

    sync_length_sum_frame_parser_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_rx_byte      (i_rx_byte),
        .i_timeout_ms   (i_timeout_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_event_res    (o_event_res),
        .o_data         (o_data),
        .o_position     (o_position),
        .o_frame_length (o_frame_length),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // Beats waiting to be driven and events the deframer should produce.
    t_item   beat_queue[$];
    t_result predicted_events[$];
    int      beats_pushed = 0;
    int      beats_taken  = 0;
    int      fail_count   = 0;
    int      hold_left    = 0;
    bit      hold_done    = 1'b0;
    bit      tick_spray   = 1'b0;
    logic    calm;

    // Shadow copy of the deframer state and its capacity register.
    logic [7:0]  capacity  = CAPACITY_RST;
    t_rx_state   rx_state  = ST_IDLE;
    logic [7:0]  sum_acc   = 8'd0;
    logic [7:0]  len_seen  = 8'd0;
    logic [7:0]  body_pos  = 8'd0;
    logic [15:0] ms_count  = 16'd0;
    logic [15:0] ms_limit  = 16'd0;

    // Neither side idles while this window of beats goes through.
    assign calm = (beats_taken >= 300) && (beats_taken < 500);

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advance the shadow deframer by one accepted beat.
    task automatic deframe_beat(input t_item beat);
        t_result ev;
        bit      fire;
        ev   = '0;
        fire = 1'b0;
        if (beat.command == CMD_START) begin
            sum_acc  = 8'd0;
            len_seen = 8'd0;
            body_pos = 8'd0;
            ms_count = 16'd0;
            ms_limit = beat.timeout_ms;
            if (beat.timeout_ms == 16'd0) begin
                rx_state     = ST_IDLE;
                fire         = 1'b1;
                ev.event_res = EV_TIMEOUT;
            end else begin
                rx_state = ST_HUNT;
            end
        end else if (rx_state != ST_IDLE && beat.command == CMD_BYTE) begin
            case (rx_state)
                ST_HUNT: begin
                    if (beat.rx_byte == SYNC_BYTE) begin
                        sum_acc  = beat.rx_byte;
                        rx_state = ST_LEN;
                    end
                end
                ST_LEN: begin
                    len_seen = beat.rx_byte;
                    sum_acc  = sum_acc + beat.rx_byte;
                    body_pos = 8'd0;
                    if (beat.rx_byte != 8'd0 && beat.rx_byte <= capacity)
                        rx_state = ST_BODY;
                    else
                        rx_state = ST_HUNT;
                end
                ST_BODY: begin
                    fire         = 1'b1;
                    ev.event_res = EV_BYTE;
                    ev.data      = beat.rx_byte;
                    ev.position  = body_pos;
                    sum_acc      = sum_acc + beat.rx_byte;
                    body_pos     = body_pos + 8'd1;
                    if (body_pos == len_seen)
                        rx_state = ST_SUM;
                end
                ST_SUM: begin
                    if (beat.rx_byte == sum_acc) begin
                        rx_state = ST_RSSI;
                    end else begin
                        rx_state     = ST_HUNT;
                        fire         = 1'b1;
                        ev.event_res = EV_DISCARD;
                    end
                end
                ST_RSSI: begin
                    rx_state     = ST_IDLE;
                    fire         = 1'b1;
                    ev.event_res = EV_ACCEPT;
                end
                default: begin
                end
            endcase
        end else if (rx_state != ST_IDLE && beat.command == CMD_TICK) begin
            if (ms_count < ms_limit)
                ms_count = ms_count + 16'd1;
            if (ms_count >= ms_limit) begin
                rx_state     = ST_IDLE;
                fire         = 1'b1;
                ev.event_res = EV_TIMEOUT;
            end
        end
        if (fire) begin
            ev.frame_length = len_seen;
            predicted_events.push_back(ev);
        end
    endtask

    // Input side: present queued beats, idling at random between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                deframe_beat({i_command, i_rx_byte, i_timeout_ms});
                beats_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (beat_queue.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
                    i_in_valid   <= 1'b1;
                    i_command    <= beat_queue[0].command;
                    i_rx_byte    <= beat_queue[0].rx_byte;
                    i_timeout_ms <= beat_queue[0].timeout_ms;
                    void'(beat_queue.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string label, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // Output side: check each result beat and stall at random, with one long hold-off.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_event_res, o_data, o_position, o_frame_length};
                if (predicted_events.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no event, actual event %0d data %0d",
                             $time, got.event_res, got.data);
                end else begin
                    want = predicted_events.pop_front();
                    compare_field("event", 8'(want.event_res), 8'(got.event_res));
                    compare_field("data", want.data, got.data);
                    compare_field("position", want.position, got.position);
                    compare_field("frame_length", want.frame_length, got.frame_length);
                end
            end
            if (!hold_done && beats_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 10);
            end
        end
    end

    // Ends the run when nothing moves on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("sync_length_sum_frame_parser_unit: mismatch");
        $finish;
    end

    task automatic add_beat(input logic [1:0] cmd, input logic [7:0] data,
                            input logic [15:0] tmo);
        t_item beat;
        beat.command    = cmd;
        beat.rx_byte    = data;
        beat.timeout_ms = tmo;
        beat_queue.push_back(beat);
        beats_pushed++;
    endtask

    // A received byte, sometimes preceded by a millisecond tick.
    task automatic add_rx(input logic [7:0] data);
        if (tick_spray && $urandom_range(99) < 4)
            add_beat(CMD_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        add_beat(CMD_BYTE, data, 16'($urandom_range(0, 65535)));
    endtask

    // Mostly short bodies; only now and then up to the full capacity.
    function automatic logic [7:0] pick_len();
        int top;
        top = (capacity < 12) ? int'(capacity) : 12;
        if (capacity == 8'd0)
            return 8'($urandom_range(1, 255));
        if ($urandom_range(99) < 3)
            return 8'($urandom_range(1, capacity));
        return 8'($urandom_range(1, top));
    endfunction

    // A length the parser must reject at the present capacity.
    function automatic logic [7:0] pick_bad_len();
        int cap_i;
        cap_i = int'(capacity);
        if (cap_i == 255 || $urandom_range(1) == 0)
            return 8'd0;
        return 8'($urandom_range(cap_i + 1, 255));
    endfunction

    // Sync, length, body, checksum and signal strength, or a broken variant.
    task automatic add_frame(input logic [7:0] len, input t_frame_kind kind);
        logic [7:0] sum;
        logic [7:0] data;
        int         stop_at;
        sum = SYNC_BYTE + len;
        add_rx(SYNC_BYTE);
        add_rx(len);
        if (len == 8'd0 || len > capacity)
            return;
        stop_at = (kind == FR_CUT) ? int'($urandom_range(0, len - 1)) : int'(len);
        for (int k = 0; k < stop_at; k++) begin
            data = 8'($urandom_range(0, 255));
            sum  = sum + data;
            add_rx(data);
        end
        if (kind == FR_GOOD) begin
            add_rx(sum);
            add_rx(8'($urandom_range(0, 255)));
        end else if (kind == FR_BAD_SUM) begin
            add_rx(sum ^ (8'd1 << $urandom_range(0, 7)));
        end
    endtask

    // One receive attempt: start, some noise, maybe a broken frame, then a good one if not cut.
    task automatic add_attempt();
        int          pick;
        logic [15:0] tmo;
        pick = $urandom_range(99);
        if (pick < 5)
            tmo = 16'd0;
        else if (pick < 15)
            tmo = 16'($urandom_range(1, 6));
        else if (pick < 50)
            tmo = 16'($urandom_range(0, 65535));
        else
            tmo = 16'($urandom_range(1000, 65535));
        add_beat(CMD_START, 8'($urandom_range(0, 255)), tmo);
        repeat ($urandom_range(0, 2))
            add_rx(8'($urandom_range(0, 255)));
        pick = $urandom_range(99);
        if (pick < 10) begin
            add_frame(pick_bad_len(), FR_GOOD);
        end else if (pick < 22) begin
            add_frame(pick_len(), FR_BAD_SUM);
        end else if (pick < 30) begin
            // The next attempt restarts this one in the middle of a frame.
            add_frame(pick_len(), FR_CUT);
            return;
        end else if (pick < 34) begin
            add_beat(CMD_UNUSED, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end
        add_frame(pick_len(), FR_GOOD);
        if ($urandom_range(99) < 10)
            add_rx(8'($urandom_range(0, 255)));
    endtask

    task automatic add_attempts(input int count);
        int stop_at;
        stop_at = beats_pushed + count;
        while (beats_pushed < stop_at)
            add_attempt();
    endtask

    // Waits until every beat is taken and every event seen, then lets the pipe empty.
    task automatic wait_idle();
        while (beats_taken != beats_pushed || predicted_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        capacity = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset capacity.
        add_beat(CMD_BYTE, SYNC_BYTE, 16'h0000);
        add_beat(CMD_TICK, 8'hFF, 16'hFFFF);
        add_beat(CMD_UNUSED, 8'hFF, 16'hFFFF);
        add_beat(CMD_START, 8'h00, 16'h0000);
        add_beat(CMD_START, 8'hFF, 16'hFFFF);
        add_rx(8'h00);
        add_rx(8'hFF);
        add_frame(8'd0, FR_GOOD);
        add_beat(CMD_UNUSED, 8'h00, 16'h0000);
        add_frame(8'd2, FR_BAD_SUM);
        add_beat(CMD_START, 8'h00, 16'd2);
        add_beat(CMD_TICK, 8'h00, 16'h0000);
        add_beat(CMD_TICK, 8'h00, 16'h0000);
        add_beat(CMD_START, 8'h00, 16'd100);
        add_frame(8'd1, FR_GOOD);

        // Random attempts, one of them with the longest body.
        tick_spray = 1'b1;
        add_beat(CMD_START, 8'($urandom_range(0, 255)), 16'hFFFF);
        add_frame(8'd255, FR_GOOD);
        add_attempts(200);
        wait_idle();

        write_capacity(8'd1);
        add_attempts(100);
        wait_idle();

        write_capacity(8'd0);
        add_attempts(90);
        wait_idle();

        write_capacity(8'($urandom_range(2, 254)));
        add_attempts(140);
        wait_idle();

        write_capacity(8'd255);
        add_attempts(120);
        wait_idle();

        if (fail_count == 0)
            $display("sync_length_sum_frame_parser_unit: match");
        else
            $display("sync_length_sum_frame_parser_unit: mismatch");
        $finish;
    end

endmodule
